@@ rtl/nctc_pkg.sv @@
// nctc_pkg: shared types, constants and codes for the nearest cell transition counter
// no dependencies
`default_nettype none
package nctc_pkg;
  localparam int unsigned MaxCells  = 64;
  localparam int unsigned MaxDates  = 32;
  localparam int unsigned CoordW    = 24;
  localparam int unsigned DistW     = 49;
  localparam int unsigned CountW    = 32;
  localparam int unsigned NumCellsW = 7;
  localparam int unsigned NumDatesW = 6;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_READ     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_NUM_CELLS = 1'b0,
    REG_NUM_DATES = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_CNT_RD,
    ST_CNT_WAIT,
    ST_CNT_WR,
    ST_OUT
  } state_e;

  // scan unit control from sequencer
  typedef struct packed {
    logic start;
    logic valid;
    logic last;
  } scan_ctrl_t;
endpackage
`default_nettype wire

@@ rtl/nctc_scan.sv @@
// nctc_scan: squared distance pipeline and running minimum over codebook reads
// depends on nctc_pkg
`default_nettype none
module nctc_scan #(
  parameter int unsigned CellW = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire nctc_pkg::scan_ctrl_t        ctrl_i,
  input  wire logic [CellW-1:0]            idx_i,
  input  wire logic [nctc_pkg::CoordW-1:0] px_i,
  input  wire logic [nctc_pkg::CoordW-1:0] py_i,
  input  wire logic [2*nctc_pkg::CoordW-1:0] entry_i,
  output logic                             done_o,
  output logic [CellW-1:0]                 best_o,
  output logic [nctc_pkg::DistW-1:0]       dist_o
);
  localparam int unsigned CW = nctc_pkg::CoordW;

  logic [CW-1:0]     dx, dy, ex, ey;
  logic [2*CW-1:0]   sqx_q, sqy_q;
  logic              v1_q, l1_q, s1_q;
  logic [CellW-1:0]  i1_q;
  logic [nctc_pkg::DistW-1:0] d;
  logic [nctc_pkg::DistW-1:0] best_d_q;
  logic [CellW-1:0]  best_q;
  logic              done_q;

  // absolute differences and squared distance sum
  always_comb begin
    ex = entry_i[CW-1:0];
    ey = entry_i[2*CW-1:CW];
    dx = (px_i >= ex) ? px_i - ex : ex - px_i;
    dy = (py_i >= ey) ? py_i - ey : ey - py_i;
    d  = {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      l1_q <= 1'b0;
      s1_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.valid;
      l1_q <= ctrl_i.valid & ctrl_i.last;
      s1_q <= ctrl_i.valid & ctrl_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= dx * dx;
    sqy_q <= dy * dy;
    i1_q  <= idx_i;
  end

  // running minimum, lowest index wins a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v1_q & l1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && (s1_q || d < best_d_q)) begin
      best_d_q <= d;
      best_q   <= i1_q;
    end
  end

  assign done_o = done_q;
  assign best_o = best_q;
  assign dist_o = best_d_q;
endmodule
`default_nettype wire

@@ rtl/nctc_counters.sv @@
// nctc_counters: occupancy and transition counter memories, zeroed by a clear sweep that the top level drives
// depends on nctc_pkg
`default_nettype none
module nctc_counters #(
  parameter int unsigned OccAw = 11,
  parameter int unsigned TrnAw = 17
) (
  input  wire logic                         clk_i,
  input  wire logic [OccAw-1:0]             occ_addr_i,
  input  wire logic [TrnAw-1:0]             trn_addr_i,
  input  wire logic                         we_i,
  input  wire logic                         occ_we_i,
  input  wire logic [nctc_pkg::CountW-1:0]  occ_wdata_i,
  input  wire logic [nctc_pkg::CountW-1:0]  trn_wdata_i,
  output logic [nctc_pkg::CountW-1:0]       occ_rdata_o,
  output logic [nctc_pkg::CountW-1:0]       trn_rdata_o
);
  logic [nctc_pkg::CountW-1:0] occ_mem [2**OccAw];
  logic [nctc_pkg::CountW-1:0] trn_mem [2**TrnAw];

  // occupancy memory
  always_ff @(posedge clk_i) begin
    if (we_i && occ_we_i) occ_mem[occ_addr_i] <= occ_wdata_i;
    occ_rdata_o <= occ_mem[occ_addr_i];
  end

  // transition memory
  always_ff @(posedge clk_i) begin
    if (we_i) trn_mem[trn_addr_i] <= trn_wdata_i;
    trn_rdata_o <= trn_mem[trn_addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/nearest_cell_transition_counter.sv @@
// nearest_cell_transition_counter: top level, sequencer, codebook memory
// depends on nctc_pkg, nctc_scan, nctc_counters
//
// channel   | dir | fields (low bit up)
// s_axis    | in  | tuser: cmd; tdata: date, cell_req, prev_cell, coord_x, coord_y
// m_axis    | out | tuser: status; tdata: nearest_cell, min_distance, occupancy, transition_count
// cfg       | in  | 0 num_cells, 1 num_dates
//
// classify: one codebook read per cell, then the scan pipeline drains, then a counter
//   read-modify-write, then the result is loaded into the output register
// load, unused cmd, classify or read out of range: straight to output; read: counter read, then output
// one item at a time: the next item is taken only once the result has been taken,
//   a stalled result holds in the output register and blocks the input
// after reset a clearing pass over every counter address zeroes the counters;
// no item is accepted during it
`default_nettype none
module nearest_cell_transition_counter #(
  parameter int unsigned MAX_CELLS = nctc_pkg::MaxCells,
  parameter int unsigned MAX_DATES = nctc_pkg::MaxDates
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // cmd[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  // date[4:0] cell_req[10:5] prev_cell[16:11] coord_x[40:17] coord_y[64:41]
  input  wire logic [71:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // status[0]
  output logic               m_axis_tuser,
  // nearest_cell[5:0] min_distance[54:6] occupancy[86:55] transition_count[118:87]
  output logic [119:0]       m_axis_tdata,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [6:0]    cfg_data_i
);
  localparam int unsigned CellAw = $clog2(MAX_CELLS);
  localparam int unsigned DateAw = $clog2(MAX_DATES);
  localparam int unsigned OccAw  = DateAw + CellAw;
  localparam int unsigned TrnAw  = DateAw + 2 * CellAw;
  localparam int unsigned CW     = nctc_pkg::CoordW;
  localparam logic [31:0] CntMax = '1;

  nctc_pkg::state_e state_q, state_d;

  logic [6:0] num_cells_q;
  logic [5:0] num_dates_q;
  logic [8:0] nc;       // saturated counts
  logic [8:0] nd;

  // item fields
  logic [1:0]  in_cmd;
  logic [4:0]  in_date;
  logic [5:0]  in_cell, in_prev;
  logic [CW-1:0] in_x, in_y;

  logic [1:0]  cmd_q;
  logic [4:0]  date_q;
  logic [5:0]  cell_q, prev_q;
  logic [CW-1:0] x_q, y_q;
  logic [5:0]  prev_cell_q;

  logic [CellAw:0]  scan_cnt_q, scan_cnt_d;
  logic [TrnAw:0]   clr_q;
  logic             accept;

  // output register
  logic        out_valid_q;
  logic        st_q;
  logic [5:0]  near_q;
  logic [48:0] dist_q;
  logic [31:0] occ_q, trn_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cells_q <= 7'd64;
      num_dates_q <= 6'd32;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == nctc_pkg::REG_NUM_CELLS) num_cells_q <= cfg_data_i;
      else num_dates_q <= cfg_data_i[5:0];
    end
  end

  always_comb begin
    nc = (num_cells_q == 7'd0) ? 9'd1 :
         ({2'b0, num_cells_q} > 9'(MAX_CELLS)) ? 9'(MAX_CELLS) : {2'b0, num_cells_q};
    nd = (num_dates_q < 6'd2) ? 9'd2 :
         ({3'b0, num_dates_q} > 9'(MAX_DATES)) ? 9'(MAX_DATES) : {3'b0, num_dates_q};
  end

  assign in_cmd  = s_axis_tuser;
  assign in_date = s_axis_tdata[4:0];
  assign in_cell = s_axis_tdata[10:5];
  assign in_prev = s_axis_tdata[16:11];
  assign in_x    = s_axis_tdata[40:17];
  assign in_y    = s_axis_tdata[64:41];

  assign s_axis_tready = (state_q == nctc_pkg::ST_IDLE) && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // range checks on the held item
  logic date_ok, cell_ok, prev_ok, cls_ok;
  assign date_ok = {4'b0, date_q} < nd;
  assign cell_ok = {3'b0, cell_q} < nc;
  assign prev_ok = {3'b0, prev_q} < nc;
  assign cls_ok  = date_ok && (date_q != 5'd0);

  // item register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd;
      date_q <= in_date;
      cell_q <= in_cell;
      prev_q <= in_prev;
      x_q    <= in_x;
      y_q    <= in_y;
    end
  end

  // codebook memory
  logic [2*CW-1:0] cb_mem [2**OccAw];
  logic [2*CW-1:0] cb_rdata_q;
  logic            cb_we;
  logic [OccAw-1:0] cb_raddr;
  assign cb_we    = (state_q == nctc_pkg::ST_SCAN) && (cmd_q == nctc_pkg::CMD_LOAD)
                    && date_ok && cell_ok;
  assign cb_raddr = {date_q[DateAw-1:0], scan_cnt_q[CellAw-1:0]};
  always_ff @(posedge clk_i) begin
    if (cb_we) cb_mem[{date_q[DateAw-1:0], cell_q[CellAw-1:0]}] <= {y_q, x_q};
    cb_rdata_q <= cb_mem[cb_raddr];
  end

  // scan unit
  nctc_pkg::scan_ctrl_t sc_q;
  logic [CellAw-1:0] sidx_q;
  logic              sdone;
  logic [CellAw-1:0] sbest;
  logic [48:0]       sdist;
  logic              scan_rd;
  assign scan_rd = (state_q == nctc_pkg::ST_SCAN) && (cmd_q == nctc_pkg::CMD_CLASSIFY)
                   && cls_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
    end else begin
      sc_q.valid <= scan_rd;
      sc_q.start <= scan_rd && (scan_cnt_q == '0);
      sc_q.last  <= scan_rd && ({{(8-CellAw){1'b0}}, scan_cnt_q} + 9'd1 == nc);
    end
  end
  always_ff @(posedge clk_i) sidx_q <= scan_cnt_q[CellAw-1:0];

  nctc_scan #(.CellW(CellAw)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sc_q),
    .idx_i   (sidx_q),
    .px_i    (x_q),
    .py_i    (y_q),
    .entry_i (cb_rdata_q),
    .done_o  (sdone),
    .best_o  (sbest),
    .dist_o  (sdist)
  );

  // counter addressing
  logic [CellAw-1:0] tgt, src;
  logic [OccAw-1:0]  occ_addr;
  logic [TrnAw-1:0]  trn_addr;
  logic [31:0]       occ_rd, trn_rd, occ_inc, trn_inc;
  logic              cnt_we, occ_we;
  logic [CellAw-1:0] best_q;

  always_comb begin
    if (cmd_q == nctc_pkg::CMD_CLASSIFY) begin
      tgt = best_q;
      src = (date_q == 5'd1) ? '0 : prev_cell_q[CellAw-1:0];
    end else begin
      tgt = cell_q[CellAw-1:0];
      src = prev_q[CellAw-1:0];
    end
    occ_addr = {date_q[DateAw-1:0], tgt};
    trn_addr = {date_q[DateAw-1:0], src, tgt};
    occ_inc  = (occ_rd == CntMax) ? occ_rd : occ_rd + 32'd1;
    trn_inc  = (trn_rd == CntMax) ? trn_rd : trn_rd + 32'd1;
    if (state_q == nctc_pkg::ST_CLEAR) begin
      occ_addr = clr_q[OccAw-1:0];
      trn_addr = clr_q[TrnAw-1:0];
    end
    cnt_we = (state_q == nctc_pkg::ST_CLEAR) || (state_q == nctc_pkg::ST_CNT_WR);
    occ_we = (state_q == nctc_pkg::ST_CNT_WR) || (clr_q[TrnAw-1:OccAw] == '0);
  end

  nctc_counters #(.OccAw(OccAw), .TrnAw(TrnAw)) u_cnt (
    .clk_i       (clk_i),
    .occ_addr_i  (occ_addr),
    .trn_addr_i  (trn_addr),
    .we_i        (cnt_we),
    .occ_we_i    (occ_we),
    .occ_wdata_i ((state_q == nctc_pkg::ST_CLEAR) ? 32'd0 : occ_inc),
    .trn_wdata_i ((state_q == nctc_pkg::ST_CLEAR) ? 32'd0 : trn_inc),
    .occ_rdata_o (occ_rd),
    .trn_rdata_o (trn_rd)
  );

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    case (state_q)
      nctc_pkg::ST_CLEAR: begin
        if (clr_q[TrnAw-1:0] == '1) state_d = nctc_pkg::ST_IDLE;
      end
      nctc_pkg::ST_IDLE: begin
        scan_cnt_d = '0;
        if (accept) state_d = nctc_pkg::ST_SCAN;
      end
      nctc_pkg::ST_SCAN: begin
        case (cmd_q)
          nctc_pkg::CMD_CLASSIFY: begin
            if (!cls_ok) state_d = nctc_pkg::ST_OUT;
            else if ({{(8-CellAw){1'b0}}, scan_cnt_q} + 9'd1 == nc)
              state_d = nctc_pkg::ST_SCAN_LAST;
            else scan_cnt_d = scan_cnt_q + 1'b1;
          end
          nctc_pkg::CMD_READ: begin
            state_d = (date_ok && cell_ok && prev_ok) ? nctc_pkg::ST_CNT_RD
                                                      : nctc_pkg::ST_OUT;
          end
          default: state_d = nctc_pkg::ST_OUT;
        endcase
      end
      nctc_pkg::ST_SCAN_LAST: begin
        if (sdone) state_d = nctc_pkg::ST_CNT_RD;
      end
      nctc_pkg::ST_CNT_RD:   state_d = nctc_pkg::ST_CNT_WAIT;
      nctc_pkg::ST_CNT_WAIT: begin
        state_d = (cmd_q == nctc_pkg::CMD_CLASSIFY) ? nctc_pkg::ST_CNT_WR : nctc_pkg::ST_OUT;
      end
      nctc_pkg::ST_CNT_WR:   state_d = nctc_pkg::ST_OUT;
      nctc_pkg::ST_OUT:      state_d = nctc_pkg::ST_IDLE;
      default:               state_d = nctc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nctc_pkg::ST_CLEAR;
      scan_cnt_q  <= '0;
      clr_q       <= '0;
      prev_cell_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      if (state_q == nctc_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == nctc_pkg::ST_CNT_WR) prev_cell_q <= 6'(best_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sdone) begin
      best_q <= sbest;
      dist_q <= sdist;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == nctc_pkg::ST_OUT) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nctc_pkg::ST_CNT_WAIT) begin
      occ_q <= (cmd_q == nctc_pkg::CMD_CLASSIFY) ? occ_inc : occ_rd;
      trn_q <= (cmd_q == nctc_pkg::CMD_CLASSIFY) ? trn_inc : trn_rd;
    end
    // counts start from zero for every new item
    if (accept) begin
      occ_q <= '0;
      trn_q <= '0;
    end
    if (state_q == nctc_pkg::ST_OUT) begin
      case (cmd_q)
        nctc_pkg::CMD_LOAD: st_q <= !(date_ok && cell_ok);
        nctc_pkg::CMD_CLASSIFY: st_q <= !cls_ok;
        nctc_pkg::CMD_READ: st_q <= !(date_ok && cell_ok && prev_ok);
        default: st_q <= 1'b1;
      endcase
    end
  end

  logic [5:0]  out_near;
  logic [48:0] out_dist;
  always_comb begin
    out_near = '0;
    out_dist = '0;
    if (cmd_q == nctc_pkg::CMD_CLASSIFY) begin
      if (!st_q) begin
        out_near = 6'(best_q);
        out_dist = dist_q;
      end
    end else if (cmd_q != nctc_pkg::CMD_NONE) begin
      out_near = cell_q;
    end
  end

  assign near_q        = out_near;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = st_q;
  assign m_axis_tdata  = {1'b0, trn_q, occ_q, out_dist, near_q};

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == nctc_pkg::ST_IDLE) else $error("work during pending output");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nctc_pkg::ST_SCAN |-> {{(8-CellAw){1'b0}}, scan_cnt_q} < nc)
    else $error("scan beyond cell count");
endmodule
`default_nettype wire
